// File: hdl/urrb_pkg.sv
// Shared types, codes and constants of the serial receive ring buffer.
package urrb_pkg;

   localparam int DEFAULT_DEPTH = 16;
   localparam int DATA_W        = 8;
   localparam int FILL_W        = 4;
   localparam int STATUS_W      = 3;
   localparam int OP_W          = 2;

   typedef enum logic [OP_W-1:0] {
      OP_RECEIVE = 2'd0,
      OP_READ    = 2'd1,
      OP_DISCARD = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_EMPTY_READ = 3'd1,
      ST_LINE_ERROR = 3'd2,
      ST_FILTERED   = 3'd3,
      ST_OVERFLOW   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic exec;
      logic load_data;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic mem_read;
   } dp_stat_type;

endpackage

// File: hdl/urrb_if.sv
// Channel interfaces of the serial receive ring buffer: request, response, register write.
interface urrb_req_if;
   import urrb_pkg::*;
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [DATA_W-1:0] rx_byte;
   logic              rx_error;
   logic              advance;
   modport source (output valid, op, rx_byte, rx_error, advance, input ready);
   modport sink   (input valid, op, rx_byte, rx_error, advance, output ready);
endinterface

interface urrb_rsp_if;
   import urrb_pkg::*;
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   read_data;
   logic [FILL_W-1:0]   fill_count;
   logic [STATUS_W-1:0] status;
   modport source (output valid, read_data, fill_count, status, input ready);
   modport sink   (input valid, read_data, fill_count, status, output ready);
endinterface

interface urrb_csr_if;
   import urrb_pkg::*;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] device_id;
   modport source (output valid, device_id, input ready);
   modport sink   (input valid, device_id, output ready);
endinterface

// File: hdl/urrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module urrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/urrb_ctrl.sv
// Controller state machine: accepts an item, waits for memory data when a read reaches it, presents the result.
module urrb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  urrb_pkg::dp_stat_type stat,
   output urrb_pkg::cmd_type     cmd
);
   import urrb_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      cmd.exec      = 1'b0;
      cmd.load_data = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.exec = 1'b1;
               state_in = stat.mem_read ? S_FETCH : S_RESP;
            end
         end
         S_FETCH: begin
            cmd.load_data = 1'b1;
            state_in      = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // A new item is never taken while a result is still on offer.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted while a response is pending");

   // Memory data is captured only in the cycle right after an accepted read.
   a_load_after_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load_data |-> $past(cmd.exec && stat.mem_read))
      else $error("read data captured without a preceding read");

   // A result that is offered stays offered until it is taken.
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn before it was taken");

endmodule

// File: hdl/urrb_dp.sv
// Datapath: ring indices, start-byte filter register, slot memory and result registers.
module urrb_dp #(
   parameter int DEPTH = urrb_pkg::DEFAULT_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  urrb_pkg::cmd_type             cmd,
   output urrb_pkg::dp_stat_type         stat,
   input  logic [urrb_pkg::OP_W-1:0]     req_op,
   input  logic [urrb_pkg::DATA_W-1:0]   req_rx_byte,
   input  logic                          req_rx_error,
   input  logic                          req_advance,
   input  logic                          csr_we,
   input  logic [urrb_pkg::DATA_W-1:0]   csr_device_id,
   output logic [urrb_pkg::DATA_W-1:0]   rsp_read_data,
   output logic [urrb_pkg::FILL_W-1:0]   rsp_fill_count,
   output logic [urrb_pkg::STATUS_W-1:0] rsp_status
);
   import urrb_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = IW + 1;

   logic [IW-1:0]     wr_ff, wr_in;
   logic [IW-1:0]     rd_ff, rd_in;
   logic [DATA_W-1:0] device_id_ff;
   logic [DATA_W-1:0] data_ff;
   logic [FILL_W-1:0] fill_ff, fill_in;
   status_type        status_ff, status_in;

   logic [IW-1:0]        wr_next, rd_next;
   logic                 empty, filtered;
   logic                 mem_we, mem_re;
   logic [DATA_W-1:0]    mem_rdata;
   logic [CW-1:0]        count;
   logic [CW+FILL_W-1:0] count_ext;
   op_type               op;

   assign op       = op_type'(req_op);
   assign empty    = (wr_ff == rd_ff);
   assign wr_next  = (wr_ff == IW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
   assign rd_next  = (rd_ff == IW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
   // While empty and the ID is nonzero, only the ID byte or its bit-0 twin may start a message.
   assign filtered = empty && (device_id_ff != '0) &&
                     ((req_rx_byte ^ device_id_ff) >> 1) != '0;

   always_comb begin
      wr_in     = wr_ff;
      rd_in     = rd_ff;
      status_in = ST_OK;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      unique case (op)
         OP_RECEIVE: begin
            if (req_rx_error) begin
               wr_in     = rd_ff;
               status_in = ST_LINE_ERROR;
            end else if (filtered) begin
               status_in = ST_FILTERED;
            end else if (wr_next == rd_ff) begin
               wr_in     = rd_ff;
               status_in = ST_OVERFLOW;
            end else begin
               wr_in  = wr_next;
               mem_we = 1'b1;
            end
         end
         OP_READ: begin
            if (empty) begin
               status_in = ST_EMPTY_READ;
            end else begin
               mem_re = 1'b1;
               if (req_advance) begin
                  rd_in = rd_next;
               end
            end
         end
         OP_DISCARD: begin
            wr_in = rd_ff;
         end
         OP_NONE: begin
            wr_in = wr_ff;
         end
         default: begin
            wr_in = wr_ff;
         end
      endcase
   end

   assign stat.mem_read = mem_re;

   // Bytes held after the step, modulo DEPTH, kept to the low output bits.
   assign count     = (wr_in >= rd_in) ? ({1'b0, wr_in} - {1'b0, rd_in})
                                       : ({1'b0, wr_in} + CW'(DEPTH) - {1'b0, rd_in});
   assign count_ext = {{FILL_W{1'b0}}, count};
   assign fill_in   = count_ext[FILL_W-1:0];

   urrb_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock (clock),
      .we    (cmd.exec && mem_we),
      .waddr (wr_next),
      .wdata (req_rx_byte),
      .re    (cmd.exec && mem_re),
      .raddr (rd_next),
      .rdata (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff        <= '0;
         rd_ff        <= '0;
         device_id_ff <= '0;
      end else begin
         if (cmd.exec) begin
            wr_ff <= wr_in;
            rd_ff <= rd_in;
         end
         if (csr_we) begin
            device_id_ff <= csr_device_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         data_ff   <= '0;
         fill_ff   <= fill_in;
         status_ff <= status_in;
      end else if (cmd.load_data) begin
         data_ff <= mem_rdata;
      end
   end

   assign rsp_read_data  = data_ff;
   assign rsp_fill_count = fill_ff;
   assign rsp_status     = status_ff;

   // The slot under the read index is the one always left empty.
   a_keep_gap: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && mem_we) |-> (wr_next != rd_ff))
      else $error("write into the reserved empty slot");

   // A flush by overflow, line error or discard leaves the ring empty.
   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && ((op == OP_DISCARD) ||
                    (op == OP_RECEIVE && (req_rx_error || status_in == ST_OVERFLOW))))
      |=> (wr_ff == rd_ff))
      else $error("ring not empty after a flush");

   // A failed read leaves the data field at zero.
   a_empty_read_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && op == OP_READ && empty) |=> (data_ff == '0 && !cmd.load_data))
      else $error("empty read returned data");

endmodule

// File: hdl/uart_rx_ring_buffer_filter.sv
// Top level of the serial receive ring buffer with start-byte filter.
//
// Usage: each request item carries one operation. A receive stores a byte from
// the serial receiver, a read returns the oldest stored byte (and removes it
// when advance is set), and a discard empties the ring. Every request yields
// exactly one response item with the read data, the number of bytes held after
// the operation, and a status code.
// The ring holds at most DEPTH-1 bytes in a slot memory with registered read.
// A byte arriving with a line error empties the ring, and so does a receive
// into a full ring, which reports overflow. While the ring is empty, a nonzero
// device ID admits only that ID or the byte that differs from it in bit 0.
// The ID must be written through the register channel only while the block
// is idle; the block does not enforce this. Timing: a request is taken while
// the controller is idle; the response is offered in the cycle after, or
// after a fetch state for a read that reaches the slot memory, since the
// memory read data is registered. One item is in flight at a time. A stalled
// response holds its payload, and no new request is taken until it is
// accepted. Reset empties the ring and clears the device ID; slot contents
// are not cleared, which needs no clearing pass.
module uart_rx_ring_buffer_filter #(
   parameter int DEPTH = urrb_pkg::DEFAULT_DEPTH
) (
   input logic        clock,
   input logic        reset,
   urrb_req_if.sink   req_chan,
   urrb_rsp_if.source rsp_chan,
   urrb_csr_if.sink   csr_chan
);
   import urrb_pkg::*;

   cmd_type     cmd;
   dp_stat_type stat;

   // Always ready; writes must come only while idle, unchecked by the block.
   assign csr_chan.ready = 1'b1;

   // The controller sequences accept, memory fetch and response.
   urrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the ring state and the result registers.
   urrb_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_op         (req_chan.op),
      .req_rx_byte    (req_chan.rx_byte),
      .req_rx_error   (req_chan.rx_error),
      .req_advance    (req_chan.advance),
      .csr_we         (csr_chan.valid),
      .csr_device_id  (csr_chan.device_id),
      .rsp_read_data  (rsp_chan.read_data),
      .rsp_fill_count (rsp_chan.fill_count),
      .rsp_status     (rsp_chan.status)
   );

endmodule

// File: test/uart_rx_ring_buffer_filter_tb.sv
// Self-checking testbench for the serial receive ring buffer with start-byte filter.
module uart_rx_ring_buffer_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import urrb_pkg::*;

   localparam int RING_DEPTH    = DEFAULT_DEPTH;
   // Generous bound on the whole run.
   localparam int CYCLE_LIMIT   = 200000;
   // Quiet cycles required before a device ID write, beyond the last response.
   localparam int SETTLE_CYCLES = 4;
   // Cycles allowed after the last response for any stray item to show up.
   localparam int DRAIN_CYCLES  = 12;
   // Percent of cycles in which each side idles outside the calm window.
   localparam int IDLE_PERCENT  = 38;
   // The receiver stops once for a long stretch after this many requests.
   localparam int HOLD_AFTER    = 300;
   localparam int HOLD_CYCLES   = 80;
   // Requests in this range are sent and received with no idling at all.
   localparam int CALM_FIRST    = 500;
   localparam int CALM_LAST     = 650;

   typedef enum bit {
      ENTRY_REQUEST,
      ENTRY_ID_WRITE
   } entry_kind_type;

   // One pending entry for the driver: either a request item or an ID write.
   typedef struct {
      entry_kind_type    kind;
      op_type            op;
      logic [DATA_W-1:0] rx_byte;
      logic              rx_error;
      logic              advance;
      logic [DATA_W-1:0] id_value;
   } pending_item_type;

   typedef struct {
      logic [DATA_W-1:0] read_data;
      logic [FILL_W-1:0] fill_count;
      status_type        status;
   } ring_result_type;

   logic clock;
   logic reset;

   urrb_req_if req_chan ();
   urrb_rsp_if rsp_chan ();
   urrb_csr_if csr_chan ();

   uart_rx_ring_buffer_filter DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Items waiting to be offered, and responses the ring should still produce.
   pending_item_type pending_items[$];
   ring_result_type  expected_results[$];

   // Our own copy of the ring: write and read pointers, slot contents and the ID.
   int                wr_ptr;
   int                rd_ptr;
   logic [DATA_W-1:0] ring_slots [RING_DEPTH];
   logic [DATA_W-1:0] filter_id;

   // Handshake flags captured at the rising edge for the falling-edge drivers.
   logic req_taken;
   logic csr_taken;
   int   requests_taken;
   int   quiet_cycles;
   int   error_count;
   bit   calm;
   bit   hold_done;
   int   hold_left;

   // The ID the stimulus generator believes is in force, used to aim bytes at the filter.
   logic [DATA_W-1:0] gen_id;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Applies one accepted request to the ring copy and works out its response.
   // The ring keeps one slot empty, so a receive that would make the write
   // pointer catch up with the read pointer is an overflow and empties the ring.
   // The start filter only matters while the ring is empty and the ID is nonzero.
   task automatic predict_ring_step(input pending_item_type item,
                                    output ring_result_type res);
      int next_ptr;
      res.read_data = '0;
      res.status    = ST_OK;
      case (item.op)
         OP_RECEIVE: begin
            if (item.rx_error) begin
               // A line error throws away everything, including this byte.
               wr_ptr     = rd_ptr;
               res.status = ST_LINE_ERROR;
            end else if (wr_ptr == rd_ptr && filter_id != '0 &&
                         (item.rx_byte ^ filter_id) > 8'd1) begin
               res.status = ST_FILTERED;
            end else begin
               next_ptr = (wr_ptr + 1) % RING_DEPTH;
               if (next_ptr == rd_ptr) begin
                  wr_ptr     = rd_ptr;
                  res.status = ST_OVERFLOW;
               end else begin
                  wr_ptr               = next_ptr;
                  ring_slots[next_ptr] = item.rx_byte;
               end
            end
         end
         OP_READ: begin
            if (wr_ptr == rd_ptr) begin
               res.status = ST_EMPTY_READ;
            end else begin
               next_ptr      = (rd_ptr + 1) % RING_DEPTH;
               res.read_data = ring_slots[next_ptr];
               // Without advance the read is only a peek at the oldest byte.
               if (item.advance) begin
                  rd_ptr = next_ptr;
               end
            end
         end
         OP_DISCARD: begin
            wr_ptr = rd_ptr;
         end
         default: begin
            // The unused code leaves the ring alone.
         end
      endcase
      res.fill_count = FILL_W'((wr_ptr - rd_ptr + RING_DEPTH) % RING_DEPTH);
   endtask

   // Rising edge: check responses against the oldest expectation, then record
   // accepted requests and ID writes. Responses are taken first so that an
   // expectation pushed at this edge can never be matched at the same edge.
   always @(posedge clock) begin
      ring_result_type  want;
      ring_result_type  got;
      pending_item_type item;
      req_taken <= !reset && req_chan.valid && req_chan.ready;
      csr_taken <= !reset && csr_chan.valid && csr_chan.ready;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response: data %0d fill %0d status %0d", $time,
                        rsp_chan.read_data, rsp_chan.fill_count, rsp_chan.status);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_chan.read_data !== want.read_data) begin
                  $display("%0t: read_data mismatch: expected %0d, actual %0d", $time,
                           want.read_data, rsp_chan.read_data);
                  error_count++;
               end
               if (rsp_chan.fill_count !== want.fill_count) begin
                  $display("%0t: fill_count mismatch: expected %0d, actual %0d", $time,
                           want.fill_count, rsp_chan.fill_count);
                  error_count++;
               end
               if (rsp_chan.status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                           want.status, rsp_chan.status);
                  error_count++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            item.kind     = ENTRY_REQUEST;
            item.op       = op_type'(req_chan.op);
            item.rx_byte  = req_chan.rx_byte;
            item.rx_error = req_chan.rx_error;
            item.advance  = req_chan.advance;
            item.id_value = '0;
            predict_ring_step(item, got);
            expected_results.push_back(got);
            requests_taken++;
         end
         if (csr_chan.valid && csr_chan.ready) begin
            filter_id = csr_chan.device_id;
         end
         // An ID write waits until the count of quiet cycles reaches SETTLE_CYCLES.
         if (expected_results.size() == 0 && !req_chan.valid) begin
            quiet_cycles++;
         end else begin
            quiet_cycles = 0;
         end
         calm = requests_taken >= CALM_FIRST && requests_taken < CALM_LAST;
      end
   end

   // Falling edge: the driver. A request or ID write stays on its channel until
   // its handshake, then the next pending entry is taken from the queue. ID
   // writes go out only when the ring has answered everything sent before them.
   always @(negedge clock) begin
      pending_item_type head;
      logic             offer_req;
      logic             offer_id;
      offer_req = req_chan.valid && !req_taken;
      offer_id  = csr_chan.valid && !csr_taken;
      if (!reset && !offer_req && !offer_id && pending_items.size() != 0) begin
         head = pending_items[0];
         if (head.kind == ENTRY_ID_WRITE) begin
            if (expected_results.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
               csr_chan.device_id <= head.id_value;
               offer_id = 1'b1;
               void'(pending_items.pop_front());
            end
         end else if (calm || $urandom_range(0, 99) >= IDLE_PERCENT) begin
            req_chan.op       <= head.op;
            req_chan.rx_byte  <= head.rx_byte;
            req_chan.rx_error <= head.rx_error;
            req_chan.advance  <= head.advance;
            offer_req = 1'b1;
            void'(pending_items.pop_front());
         end
      end
      req_chan.valid <= offer_req;
      csr_chan.valid <= offer_id;
   end

   // Falling edge: the receiver. Besides random stalls it holds ready low once
   // for a long stretch while the driver keeps offering, so the block backs up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (!hold_done && requests_taken >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= calm || $urandom_range(0, 99) >= IDLE_PERCENT;
      end
   end

   task automatic add_request(input op_type op, input logic [DATA_W-1:0] rx_byte,
                              input logic rx_error, input logic advance);
      pending_item_type item;
      item.kind     = ENTRY_REQUEST;
      item.op       = op;
      item.rx_byte  = rx_byte;
      item.rx_error = rx_error;
      item.advance  = advance;
      item.id_value = '0;
      pending_items.push_back(item);
   endtask

   task automatic add_id_write(input logic [DATA_W-1:0] value);
      pending_item_type item;
      item.kind     = ENTRY_ID_WRITE;
      item.op       = OP_NONE;
      item.rx_byte  = '0;
      item.rx_error = 1'b0;
      item.advance  = 1'b0;
      item.id_value = value;
      pending_items.push_back(item);
      gen_id = value;
   endtask

   // A byte that passes the start filter: the ID itself or its bit-0 neighbor.
   function automatic logic [DATA_W-1:0] id_byte();
      return gen_id ^ DATA_W'($urandom_range(0, 1));
   endfunction

   // Random traffic for one ID setting. Most of it is built from fill bursts
   // that start with a byte the filter admits (often running into overflow),
   // drain bursts that walk the oldest bytes out, and mixed stretches that add
   // peeks, discards, line errors, the unused code and bytes the filter drops.
   task automatic add_random_traffic(input int count);
      int added;
      int pick;
      int run;
      int r;
      added = 0;
      while (added < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            repeat (8) begin
               r = $urandom_range(0, 99);
               if (r < 50) begin
                  add_request(OP_RECEIVE,
                              ($urandom_range(0, 1) != 0) ? id_byte() : DATA_W'($urandom),
                              $urandom_range(0, 19) == 0, 1'($urandom_range(0, 1)));
               end else if (r < 85) begin
                  add_request(OP_READ, DATA_W'($urandom), 1'($urandom_range(0, 1)),
                              $urandom_range(0, 3) != 0);
               end else if (r < 93) begin
                  add_request(OP_DISCARD, DATA_W'($urandom), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
               end else begin
                  add_request(OP_NONE, DATA_W'($urandom), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
               end
            end
            added += 8;
         end else if (pick < 80) begin
            run = $urandom_range(10, RING_DEPTH + 1);
            add_request(OP_RECEIVE, id_byte(), 1'b0, 1'($urandom_range(0, 1)));
            repeat (run - 1) begin
               add_request(OP_RECEIVE, DATA_W'($urandom), 1'b0, 1'($urandom_range(0, 1)));
            end
            added += run;
         end else begin
            run = $urandom_range(3, RING_DEPTH + 1);
            repeat (run) begin
               add_request(OP_READ, DATA_W'($urandom), 1'($urandom_range(0, 1)), 1'b1);
            end
            added += run;
         end
      end
   endtask

   // Stimulus and end of run. Inputs are given known values at time zero with
   // reset asserted, and the whole run is queued up front: a directed pass with
   // the filter off, a short directed filter check, then random traffic under
   // several IDs including both extremes.
   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.op        = OP_NONE;
      req_chan.rx_byte   = '0;
      req_chan.rx_error  = 1'b0;
      req_chan.advance   = 1'b0;
      rsp_chan.ready     = 1'b0;
      csr_chan.valid     = 1'b0;
      csr_chan.device_id = '0;
      req_taken          = 1'b0;
      csr_taken          = 1'b0;
      requests_taken     = 0;
      quiet_cycles       = 0;
      error_count        = 0;
      calm               = 1'b0;
      hold_done          = 1'b0;
      hold_left          = 0;
      wr_ptr             = 0;
      rd_ptr             = 0;
      filter_id          = '0;
      gen_id             = '0;

      // Filter off: empty reads, the unused code, both byte extremes, a peek
      // then removing reads, a line error, a discard with junk in the unused
      // fields, and a full ring pushed into overflow.
      add_id_write(8'h00);
      add_request(OP_READ, 8'h00, 1'b0, 1'b0);
      add_request(OP_READ, 8'hFF, 1'b1, 1'b1);
      add_request(OP_NONE, 8'hFF, 1'b1, 1'b1);
      add_request(OP_RECEIVE, 8'h00, 1'b0, 1'b1);
      add_request(OP_RECEIVE, 8'hFF, 1'b0, 1'b0);
      add_request(OP_READ, 8'h5A, 1'b1, 1'b0);
      add_request(OP_READ, 8'h00, 1'b0, 1'b1);
      add_request(OP_READ, 8'h00, 1'b0, 1'b1);
      add_request(OP_RECEIVE, 8'h3C, 1'b0, 1'b0);
      add_request(OP_RECEIVE, 8'h81, 1'b1, 1'b0);
      add_request(OP_RECEIVE, 8'h12, 1'b0, 1'b0);
      add_request(OP_DISCARD, 8'hFF, 1'b1, 1'b1);
      for (int i = 0; i < RING_DEPTH; i++) begin
         add_request(OP_RECEIVE, DATA_W'(i * 17), 1'b0, 1'b0);
      end

      // Highest ID: a foreign byte is dropped while empty, its bit-0 neighbor
      // starts a frame, and once the ring holds data anything is taken.
      add_id_write(8'hFF);
      add_request(OP_RECEIVE, 8'h12, 1'b0, 1'b0);
      add_request(OP_RECEIVE, 8'hFE, 1'b0, 1'b0);
      add_request(OP_RECEIVE, 8'h12, 1'b0, 1'b0);
      add_request(OP_READ, 8'h00, 1'b0, 1'b1);
      add_request(OP_READ, 8'h00, 1'b0, 1'b1);
      add_request(OP_RECEIVE, 8'hFF, 1'b0, 1'b0);
      add_request(OP_DISCARD, 8'h00, 1'b0, 1'b0);
      add_random_traffic(120);

      // Lowest nonzero ID, where the admitted pair is zero and one.
      add_id_write(8'h01);
      add_random_traffic(150);
      add_id_write(8'h80);
      add_random_traffic(150);
      add_id_write(DATA_W'($urandom_range(2, 254)));
      add_random_traffic(150);
      add_id_write(8'h00);
      add_random_traffic(150);
      add_id_write(DATA_W'($urandom_range(1, 255)));
      add_random_traffic(150);
      add_id_write(DATA_W'($urandom_range(1, 255)));
      add_random_traffic(150);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait until every entry has gone out and every response has come back.
      do begin
         @(negedge clock);
      end while (pending_items.size() != 0 || req_chan.valid || csr_chan.valid ||
                 expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("uart_rx_ring_buffer_filter_tb passed");
      end else begin
         $display("uart_rx_ring_buffer_filter_tb failed");
      end
      $finish;
   end

   // Watchdog: a run that has not finished by the limit has hung.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("uart_rx_ring_buffer_filter_tb failed");
      $finish;
   end

endmodule

// File: filelist.f
hdl/urrb_pkg.sv
hdl/urrb_if.sv
hdl/urrb_ram.sv
hdl/urrb_ctrl.sv
hdl/urrb_dp.sv
hdl/uart_rx_ring_buffer_filter.sv
test/uart_rx_ring_buffer_filter_tb.sv
